@@ rtl/mpgc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpgc_pkg
// Types and constants shared by the multi-point gene crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpgc_pkg;

    localparam int RAND_W    = 16;
    localparam int GENE_W    = 64;
    localparam int LEN_W     = 11;
    localparam int PTS_W     = 10;
    localparam int DIV_CNT_W = 4;

    // Longest genome the block builds, and the live bits of a gene word
    localparam int MAX_GENES = 1024;
    localparam int GENE_BITS = 64;

    localparam logic [GENE_W-1:0] GENE_MASK = {GENE_W{1'b1}} >> (GENE_W - GENE_BITS);

    localparam logic [RAND_W-1:0] PROB_RESET = 16'd32768;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd16;
    localparam logic [RAND_W-1:0] HALF_Q16   = 16'd32768;
    localparam logic [LEN_W-1:0]  MIN_LEN    = 11'd2;
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_GENES);
    localparam logic [LEN_W-1:0]  MIN_SEG    = 11'd2;

    // Configuration register indexes
    localparam logic CFG_PROB = 1'b0;
    localparam logic CFG_LEN  = 1'b1;

    // Input word commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_GENE  = 1'b1;

    typedef struct packed {
        logic load_start;
        logic div_step;
        logic gene_take;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/mpgc_in_if.sv @@
// ----------------------------------------------------------------------------
// mpgc_in_if
// Input channel: start words and gene pair words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpgc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [mpgc_pkg::GENE_W-1:0]   gene_a;
    logic [mpgc_pkg::GENE_W-1:0]   gene_b;
    logic [mpgc_pkg::RAND_W-1:0]   rand_a;
    logic [mpgc_pkg::RAND_W-1:0]   rand_b;
    logic [mpgc_pkg::RAND_W-1:0]   rand_c;

    modport source (output valid, cmd, gene_a, gene_b, rand_a, rand_b, rand_c,
                    input ready);
    modport sink   (input valid, cmd, gene_a, gene_b, rand_a, rand_b, rand_c,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/mpgc_out_if.sv @@
// ----------------------------------------------------------------------------
// mpgc_out_if
// Output channel: one child gene word per gene pair of an active child.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpgc_out_if;
    logic                        valid;
    logic                        ready;
    logic [mpgc_pkg::GENE_W-1:0] child_gene;
    logic                        from_parent_two;
    logic                        last_gene;

    modport source (output valid, child_gene, from_parent_two, last_gene,
                    input ready);
    modport sink   (input valid, child_gene, from_parent_two, last_gene,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/mpgc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpgc_ctrl
// Controller: input handshake and sequencing of the point interval divide.
// ----------------------------------------------------------------------------
`default_nettype none

module mpgc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_cmd,
    input  wire               i_out_ready,
    input  mpgc_pkg::t_status i_status,
    output logic              o_in_ready,
    output mpgc_pkg::t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;
    localparam logic [mpgc_pkg::DIV_CNT_W-1:0] DIV_LAST =
        mpgc_pkg::DIV_CNT_W'(mpgc_pkg::LEN_W - 1);

    logic                              r_state, n_state;
    logic [mpgc_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                              accept;

    // Take a word only in idle and when the result register has room for it
    assign o_in_ready = (r_state == ST_IDLE) && (!i_status.out_full || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_cmd.load_start = 1'b0;
        o_cmd.div_step   = 1'b0;
        o_cmd.gene_take  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_in_cmd == mpgc_pkg::CMD_START) begin
                    o_cmd.load_start = 1'b1;
                    n_state          = ST_DIV;
                    n_cnt            = '0;
                end else if (accept) begin
                    o_cmd.gene_take = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mpgc_dp.sv @@
// ----------------------------------------------------------------------------
// mpgc_dp
// Datapath: configuration, child state, interval divider, gene selection and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpgc_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire                             i_cfg_addr,
    input  wire  [mpgc_pkg::RAND_W-1:0]     i_cfg_wdata,
    input  mpgc_pkg::t_cmd                  i_cmd,
    input  wire  [mpgc_pkg::GENE_W-1:0]     i_gene_a,
    input  wire  [mpgc_pkg::GENE_W-1:0]     i_gene_b,
    input  wire  [mpgc_pkg::RAND_W-1:0]     i_rand_a,
    input  wire  [mpgc_pkg::RAND_W-1:0]     i_rand_b,
    input  wire  [mpgc_pkg::RAND_W-1:0]     i_rand_c,
    input  wire                             i_out_ready,
    output mpgc_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic [mpgc_pkg::GENE_W-1:0]     o_child_gene,
    output logic                            o_from_parent_two,
    output logic                            o_last_gene
);

    localparam int LW = mpgc_pkg::LEN_W;
    localparam int PW = mpgc_pkg::PTS_W;
    localparam int RW = mpgc_pkg::RAND_W;

    // Configuration
    logic [RW-1:0]  r_prob;
    logic [LW-1:0]  r_len_cfg;

    // Child state
    logic           r_active;
    logic           r_copy_only;
    logic           r_use_one;
    logic [PW-1:0]  r_pts;
    logic [PW-1:0]  r_pts_done;
    logic [LW-1:0]  r_seg_left;
    logic [LW-1:0]  r_gene_idx;
    logic [LW-1:0]  r_child_len;

    // Divider: quotient register ends as the maximum interval
    logic [LW-1:0]  r_quo;
    logic [LW-1:0]  r_rem;

    // Result register
    logic                         r_out_valid;
    logic [mpgc_pkg::GENE_W-1:0]  r_child_gene;
    logic                         r_from_two;
    logic                         r_last;

    // Start word arithmetic
    logic [LW-1:0]     len_clamp;
    logic [RW+LW-1:0]  pts_prod;
    logic [LW-1:0]     pts_raw;
    logic [LW-1:0]     len_half;
    logic [PW-1:0]     pts_sel;

    // Divide step
    logic [LW:0]       trial;
    logic [LW:0]       diff;

    // Gene word arithmetic
    logic [RW+LW-1:0]  seg_prod;
    logic [LW-1:0]     seg_w;
    logic              seg_open;
    logic [LW-1:0]     seg_eff;
    logic [LW-1:0]     seg_next;
    logic              take_one;
    logic [LW-1:0]     idx_next;
    logic              is_last;

    always_comb begin
        len_clamp = r_len_cfg;
        if (r_len_cfg < mpgc_pkg::MIN_LEN) begin
            len_clamp = mpgc_pkg::MIN_LEN;
        end else if (r_len_cfg > mpgc_pkg::MAX_LEN) begin
            len_clamp = mpgc_pkg::MAX_LEN;
        end
        pts_prod = i_rand_b * len_clamp;
        pts_raw  = pts_prod[RW+LW-1:RW];
        len_half = len_clamp >> 1;
        if (pts_raw == '0) begin
            pts_sel = PW'(1);
        end else if (pts_raw > len_half) begin
            pts_sel = len_half[PW-1:0];
        end else begin
            pts_sel = pts_raw[PW-1:0];
        end
    end

    // Restoring divide: shift one dividend bit in per step
    assign trial = {r_rem, r_quo[LW-1]};
    assign diff  = trial - {2'b00, r_pts};

    always_comb begin
        seg_prod = i_rand_a * r_quo;
        seg_w    = seg_prod[RW+LW-1:RW];
        if (seg_w <= LW'(1)) begin
            seg_w = mpgc_pkg::MIN_SEG;
        end
        seg_open = !r_copy_only && (r_seg_left == '0) && (r_pts_done < r_pts);
        seg_eff  = seg_open ? seg_w : r_seg_left;
        seg_next = seg_eff - 1'b1;
        take_one = r_copy_only || r_use_one;
        idx_next = r_gene_idx + 1'b1;
        is_last  = idx_next >= r_child_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob       <= mpgc_pkg::PROB_RESET;
            r_len_cfg    <= mpgc_pkg::LEN_RESET;
            r_active     <= 1'b0;
            r_copy_only  <= 1'b0;
            r_use_one    <= 1'b0;
            r_pts        <= '0;
            r_pts_done   <= '0;
            r_seg_left   <= '0;
            r_gene_idx   <= '0;
            r_child_len  <= '0;
            r_quo        <= '0;
            r_rem        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    mpgc_pkg::CFG_PROB: r_prob    <= i_cfg_wdata;
                    mpgc_pkg::CFG_LEN:  r_len_cfg <= i_cfg_wdata[LW-1:0];
                    default: ;
                endcase
            end

            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.load_start) begin
                r_child_len <= len_clamp;
                r_copy_only <= i_rand_a > r_prob;
                r_use_one   <= i_rand_c > mpgc_pkg::HALF_Q16;
                r_pts       <= pts_sel;
                r_pts_done  <= '0;
                r_seg_left  <= '0;
                r_gene_idx  <= '0;
                r_active    <= 1'b1;
                r_quo       <= len_clamp;
                r_rem       <= '0;
            end

            if (i_cmd.div_step) begin
                if (!diff[LW]) begin
                    r_rem <= diff[LW-1:0];
                    r_quo <= {r_quo[LW-2:0], 1'b1};
                end else begin
                    r_rem <= trial[LW-1:0];
                    r_quo <= {r_quo[LW-2:0], 1'b0};
                end
            end

            if (i_cmd.gene_take && r_active) begin
                if (seg_open) begin
                    r_pts_done <= r_pts_done + 1'b1;
                end
                if (!r_copy_only && seg_eff != '0) begin
                    r_seg_left <= seg_next;
                    if (seg_next == '0) begin
                        r_use_one <= !r_use_one;
                    end
                end
                r_gene_idx  <= idx_next;
                if (is_last) begin
                    r_active <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gene_take && r_active) begin
            r_child_gene <= (take_one ? i_gene_a : i_gene_b) & mpgc_pkg::GENE_MASK;
            r_from_two   <= !take_one;
            r_last       <= is_last;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_child_gene      = r_child_gene;
    assign o_from_parent_two = r_from_two;
    assign o_last_gene       = r_last;

endmodule

`default_nettype wire

@@ rtl/multi_point_gene_crossover_core.sv @@
// Start word: accepted, then an interval divide (one quotient bit a cycle)
// before the next word is taken. Gene word: one per cycle while the result
// register has room; its result word appears in the cycle after accept.
// A gene word with no active child is taken and gives no result.
// Reset (synchronous, active low): registers to defaults, no child active.
// ----------------------------------------------------------------------------
// multi_point_gene_crossover_core
// Builds one child chromosome from two streamed parents by multi-point
// crossover with alternating segments of random width, or by copying parent one.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_point_gene_crossover_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire                            i_cfg_addr,
    input  wire  [mpgc_pkg::RAND_W-1:0]    i_cfg_wdata,
    mpgc_in_if.sink                        i_in_ch,
    mpgc_out_if.source                     o_out_ch
);

    mpgc_pkg::t_cmd    cmd;
    mpgc_pkg::t_status status;

    mpgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_in_cmd    (i_in_ch.cmd),
        .i_out_ready (o_out_ch.ready),
        .i_status    (status),
        .o_in_ready  (i_in_ch.ready),
        .o_cmd       (cmd)
    );

    mpgc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .i_gene_a          (i_in_ch.gene_a),
        .i_gene_b          (i_in_ch.gene_b),
        .i_rand_a          (i_in_ch.rand_a),
        .i_rand_b          (i_in_ch.rand_b),
        .i_rand_c          (i_in_ch.rand_c),
        .i_out_ready       (o_out_ch.ready),
        .o_status          (status),
        .o_out_valid       (o_out_ch.valid),
        .o_child_gene      (o_out_ch.child_gene),
        .o_from_parent_two (o_out_ch.from_parent_two),
        .o_last_gene       (o_out_ch.last_gene)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_point_gene_crossover_core: a directed table
// (reset state, copy mode, length saturation, abandoned children, extremes of
// the draws), then random children over several register settings, each word
// checked against a cycle-free predictor with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam logic [10:0] GENOME_MIN   = 11'd2;
    localparam logic [10:0] GENOME_MAX   = 11'd1024;
    localparam logic [15:0] HALF         = 16'd32768;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SQUEEZE_LEN  = 80;

    typedef struct packed {
        logic        cmd;
        logic [63:0] gene_a;
        logic [63:0] gene_b;
        logic [15:0] rand_a;
        logic [15:0] rand_b;
        logic [15:0] rand_c;
    } t_pair_word;

    typedef struct packed {
        logic [63:0] gene;
        logic        from_b;
        logic        last;
    } t_child_word;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        cfg_idx;
        logic [15:0] cfg_data;
        t_pair_word  w;
        bit          has_exp;
        t_child_word exp_word;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    mpgc_in_if  pair_ch ();
    mpgc_out_if child_ch ();

    multi_point_gene_crossover_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (pair_ch),
        .o_out_ch    (child_ch)
    );

    // Predictor state
    logic [15:0] cfg_prob;
    logic [10:0] cfg_len;
    logic        copy_mode;
    logic        on_parent_one;
    logic        building;
    logic [9:0]  pts_total;
    logic [9:0]  pts_used;
    logic [10:0] seg_max;
    logic [10:0] seg_left;
    logic [10:0] gene_pos;
    logic [10:0] child_length;

    t_child_word child_q[$];
    t_stim_row   directed_rows[$];
    t_child_word no_exp = '0;

    bit gaps_on      = 1'b1;
    bit hold_off_req = 1'b0;
    int mismatches   = 0;
    int genes_checked = 0;
    int children_done = 0;
    int words_taken  = 0;
    int settings     = 0;
    int cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the predictor by one accepted word; return 1 if it yields a gene.
    function automatic bit step_child(input t_pair_word w, output t_child_word r);
        logic [10:0] len;
        logic [26:0] prod;
        logic [10:0] pts;
        bit          take_a;
        r = '0;
        if (w.cmd == mpgc_pkg::CMD_START) begin
            len = cfg_len;
            if (len < GENOME_MIN)
                len = GENOME_MIN;
            else if (len > GENOME_MAX)
                len = GENOME_MAX;
            child_length = len;
            copy_mode = w.rand_a > cfg_prob;
            prod = w.rand_b * len;
            pts = prod[26:16];
            if (pts == 0)
                pts = 11'd1;
            else if (pts > (len >> 1))
                pts = len >> 1;
            pts_total = pts[9:0];
            seg_max = len / pts;
            on_parent_one = w.rand_c > HALF;
            pts_used = '0;
            seg_left = '0;
            gene_pos = '0;
            building = 1'b1;
            return 1'b0;
        end
        if (!building)
            return 1'b0;
        if (copy_mode) begin
            take_a = 1'b1;
        end else begin
            if (seg_left == 0 && pts_used < pts_total) begin
                prod = w.rand_a * seg_max;
                seg_left = (prod[26:16] <= 11'd1) ? 11'd2 : prod[26:16];
                pts_used++;
            end
            take_a = on_parent_one;
            if (seg_left != 0) begin
                seg_left--;
                if (seg_left == 0)
                    on_parent_one = !on_parent_one;
            end
        end
        r.gene   = take_a ? w.gene_a : w.gene_b;
        r.from_b = !take_a;
        gene_pos++;
        r.last = gene_pos >= child_length;
        if (r.last)
            building = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_stim_row word_row(input logic cmd, input logic [63:0] ga,
                                           input logic [63:0] gb, input logic [15:0] ra,
                                           input logic [15:0] rb, input logic [15:0] rc);
        t_stim_row r;
        r.kind     = ROW_WORD;
        r.cfg_idx  = mpgc_pkg::CFG_PROB;
        r.cfg_data = '0;
        r.w        = {cmd, ga, gb, ra, rb, rc};
        r.has_exp  = 1'b0;
        r.exp_word = '0;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input logic cmd, input logic [63:0] ga,
                                            input logic [63:0] gb, input logic [15:0] ra,
                                            input logic [63:0] eg, input logic eb,
                                            input logic el);
        t_stim_row r;
        r = word_row(cmd, ga, gb, ra, 16'h0000, 16'h0000);
        r.has_exp  = 1'b1;
        r.exp_word = {eg, eb, el};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic idx, input logic [15:0] data);
        t_stim_row r;
        r = word_row(mpgc_pkg::CMD_GENE, '0, '0, '0, '0, '0);
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_pair_word rand_gene();
        t_pair_word w;
        w.cmd    = mpgc_pkg::CMD_GENE;
        w.gene_a = {$urandom, $urandom};
        w.gene_b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w.rand_a = 16'h0000;
            1: w.rand_a = 16'hFFFF;
            default: w.rand_a = 16'($urandom);
        endcase
        w.rand_b = 16'($urandom);
        w.rand_c = 16'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_pair_word w, input bit use_typed,
                             input t_child_word typed_exp);
        t_child_word pred;
        bit          has_result;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pair_ch.valid  <= 1'b1;
        pair_ch.cmd    <= w.cmd;
        pair_ch.gene_a <= w.gene_a;
        pair_ch.gene_b <= w.gene_b;
        pair_ch.rand_a <= w.rand_a;
        pair_ch.rand_b <= w.rand_b;
        pair_ch.rand_c <= w.rand_c;
        do @(posedge i_clk); while (pair_ch.ready !== 1'b1);
        has_result = step_child(w, pred);
        if (use_typed)
            child_q.push_back(typed_exp);
        else if (has_result)
            child_q.push_back(pred);
        if (w.cmd == mpgc_pkg::CMD_START || has_result)
            words_taken++;
    endtask

    // Drop valid, let every pending gene come out, then let the divider settle.
    task automatic wait_idle();
        pair_ch.valid <= 1'b0;
        while (child_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == mpgc_pkg::CFG_PROB)
            cfg_prob = data;
        else
            cfg_len = data[10:0];
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] prob, input logic [10:0] len,
                             input int budget, input bit squeeze);
        int         stop_at;
        int         n;
        int         sel;
        t_pair_word w;
        wait_idle();
        cfg_write(mpgc_pkg::CFG_PROB, prob);
        wait_idle();
        cfg_write(mpgc_pkg::CFG_LEN, {5'd0, len});
        settings++;
        stop_at = words_taken + budget;
        while (words_taken < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                // stray gene word: part of the child if one runs, else dropped
                send_word(rand_gene(), 1'b0, no_exp);
            end else begin
                w = rand_gene();
                w.cmd = mpgc_pkg::CMD_START;
                case ($urandom_range(0, 4))
                    0: w.rand_a = prob;
                    1: w.rand_a = (prob == 16'hFFFF) ? prob : prob + 16'd1;
                    2: w.rand_a = 16'h0000;
                    3: w.rand_a = 16'hFFFF;
                    default: w.rand_a = 16'($urandom);
                endcase
                if ($urandom_range(0, 5) == 0)
                    w.rand_b = 16'hFFFF;
                case ($urandom_range(0, 5))
                    0: w.rand_c = HALF;
                    1: w.rand_c = HALF + 16'd1;
                    default: w.rand_c = 16'($urandom);
                endcase
                send_word(w, 1'b0, no_exp);
                // some children are cut short by the next start
                n = (sel < 15) ? int'($urandom_range(0, child_length - 1))
                               : int'(child_length);
                if (squeeze) begin
                    // offer a whole child while the receiver holds off
                    n = int'(child_length);
                    hold_off_req = 1'b1;
                    squeeze = 1'b0;
                end
                if (n > stop_at - words_taken)
                    n = stop_at - words_taken;
                repeat (n) send_word(rand_gene(), 1'b0, no_exp);
            end
        end
    endtask

    // Child gene receiver: check each accepted word, then pick next ready.
    initial begin
        int          hold;
        t_child_word exp_w;
        hold = 0;
        child_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && child_ch.valid === 1'b1 && child_ch.ready === 1'b1) begin
                if (child_q.size() == 0) begin
                    $error("child word with nothing pending: child_gene %h",
                           child_ch.child_gene);
                    mismatches++;
                end else begin
                    exp_w = child_q.pop_front();
                    if (child_ch.child_gene !== exp_w.gene) begin
                        $error("child_gene: expected %h, got %h", exp_w.gene,
                               child_ch.child_gene);
                        mismatches++;
                    end
                    if (child_ch.from_parent_two !== exp_w.from_b) begin
                        $error("from_parent_two: expected %0b, got %0b", exp_w.from_b,
                               child_ch.from_parent_two);
                        mismatches++;
                    end
                    if (child_ch.last_gene !== exp_w.last) begin
                        $error("last_gene: expected %0b, got %0b", exp_w.last,
                               child_ch.last_gene);
                        mismatches++;
                    end
                    genes_checked++;
                    if (exp_w.last)
                        children_done++;
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = SQUEEZE_LEN;
            end
            if (hold > 0) begin
                hold--;
                child_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 5);
                child_ch.ready <= 1'b0;
            end else begin
                child_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d gene words pending", cycle_count,
                 child_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_addr     = mpgc_pkg::CFG_PROB;
        i_cfg_wdata    = '0;
        pair_ch.valid  = 1'b0;
        pair_ch.cmd    = mpgc_pkg::CMD_START;
        pair_ch.gene_a = '0;
        pair_ch.gene_b = '0;
        pair_ch.rand_a = '0;
        pair_ch.rand_b = '0;
        pair_ch.rand_c = '0;

        cfg_prob      = 16'd32768;
        cfg_len       = 11'd16;
        copy_mode     = 1'b0;
        on_parent_one = 1'b0;
        building      = 1'b0;
        pts_total     = '0;
        pts_used      = '0;
        seg_max       = '0;
        seg_left      = '0;
        gene_pos      = '0;
        child_length  = '0;

        // Reset defaults: prob one half, 16 genes
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, '1, '1, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '0, '0, 16'hFFFF, 16'h0000,
                                         16'h0000));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, '1, '0, 16'h0000, '1, 1'b0,
                                          1'b0));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, 64'h0123_4567_89AB_CDEF, '1,
                                          16'hFFFF, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0));
        // Abandon the copy; draw equal to prob still crosses, start on parent two
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '1, '1, HALF, 16'h0000, HALF));
        // Length write mid-child must wait for the next start
        directed_rows.push_back(cfg_row(mpgc_pkg::CFG_LEN, 16'd0));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, '0, '1, 16'h0000, '1, 1'b1,
                                          1'b0));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, {4{16'hAAAA}}, {4{16'h5555}},
                                          16'h0000, {4{16'h5555}}, 1'b1, 1'b0));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, {4{16'h5555}}, {4{16'hAAAA}},
                                         16'hFFFF, 16'h0000, 16'h0000));
        // Length 0 acts as 2: one point, both genes from parent one
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '0, '0, 16'h0000, 16'hFFFF,
                                         16'hFFFF));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, 64'h8000_0000_0000_0001, '0,
                                          16'hFFFF, 64'h8000_0000_0000_0001, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, 64'h7FFF_FFFF_FFFF_FFFE, '1,
                                          16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b1));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, '1, '0, 16'h1234, 16'h0000,
                                         16'h0000));
        // Zero probability, oversize length saturates, point count clamps
        directed_rows.push_back(cfg_row(mpgc_pkg::CFG_PROB, 16'h0000));
        directed_rows.push_back(cfg_row(mpgc_pkg::CFG_LEN, 16'd2047));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '0, '0, 16'h0000, 16'hFFFF,
                                         16'h8001));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, {4{16'hC3C3}}, {4{16'h3C3C}},
                                         16'hFFFF, 16'h0000, 16'h0000));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, {4{16'h0F0F}}, {4{16'hF0F0}},
                                         16'h8000, 16'h0000, 16'h0000));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '0, '0, 16'h0001, 16'h0001,
                                         16'h0000));
        directed_rows.push_back(typed_row(mpgc_pkg::CMD_GENE, {4{16'h00FF}}, {4{16'hFF00}},
                                          16'h0000, {4{16'h00FF}}, 1'b0, 1'b0));
        // Full probability, odd length 3
        directed_rows.push_back(cfg_row(mpgc_pkg::CFG_PROB, 16'hFFFF));
        directed_rows.push_back(cfg_row(mpgc_pkg::CFG_LEN, 16'd3));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_START, '0, '0, 16'hFFFF, 16'h8000,
                                         16'h8001));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, 64'h1, 64'h2, 16'hFFFF,
                                         16'h0000, 16'h0000));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, 64'h3, 64'h4, 16'h0000,
                                         16'h0000, 16'h0000));
        directed_rows.push_back(word_row(mpgc_pkg::CMD_GENE, 64'h5, 64'h6, 16'hFFFF,
                                         16'h0000, 16'h0000));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(directed_rows[k].cfg_idx, directed_rows[k].cfg_data);
                settings++;
            end else begin
                send_word(directed_rows[k].w, directed_rows[k].has_exp,
                          directed_rows[k].exp_word);
            end
        end

        run_phase(16'hC000, 11'd8, 50, 1'b0);
        run_phase(16'h0000, 11'd1, 40, 1'b0);
        run_phase(16'h0001, 11'd5, 40, 1'b0);
        run_phase(16'($urandom), 11'd64, 80, 1'b1);
        run_phase(16'h7FFF, 11'd33, 50, 1'b0);
        // No idling on either side
        gaps_on = 1'b0;
        run_phase(16'hFFFF, 11'd24, 120, 1'b0);

        wait_idle();
        $display("Sent %0d parent words over %0d register settings, genome lengths 2 to 1024",
                 words_taken, settings);
        $display("Checked %0d child gene words in %0d complete children, %0d mismatches",
                 genes_checked, children_done, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
